@@ hw/rtl/volume_scaled_bipolar_pwm_dac_defines.svh @@
// Assertion macros shared by the RTL of the volume-scaled bipolar PWM DAC.
`ifndef VOLUME_SCALED_BIPOLAR_PWM_DAC_DEFINES_SVH
`define VOLUME_SCALED_BIPOLAR_PWM_DAC_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising edge outside reset.
`define VSBPD_ASSERT_IMPLY(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error("implication check failed");
// Next-cycle implication, checked on every rising edge outside reset.
`define VSBPD_ASSERT_NEXT(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define VSBPD_ASSERT_IMPLY(label, clock, reset, ante, cons)
`define VSBPD_ASSERT_NEXT(label, clock, reset, ante, cons)
`endif
`endif

@@ hw/rtl/vsbpd_pkg.sv @@
// Types, constants and the gain table of the volume-scaled bipolar PWM DAC.
package vsbpd_pkg;

  localparam int SampleW = 16;
  localparam int GainW   = 14;
  localparam int ProdW   = SampleW + GainW + 1;
  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 16;
  localparam int LevelW  = 4;

  localparam logic [CfgIdxW-1:0] CfgVolume = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgPeriod = 2'd1;

  localparam logic [LevelW-1:0] LevelReset = 4'd6;
  localparam logic [LevelW-1:0] LevelMax   = 4'd12;

  localparam logic [SampleW-1:0] SignFlip = 16'h8000;
  localparam logic [SampleW-1:0] SatHigh  = 16'h7FFF;
  localparam logic [SampleW-1:0] SatLow   = 16'h8000;

  // Output of the scaling pipe: offset-binary code with its valid bit.
  typedef struct packed {
    logic               valid;
    logic [SampleW-1:0] code;
  } scale_out_t;

  // Gain in Q12 for each volume level; level twelve reuses level eleven.
  function automatic logic [GainW-1:0] gain_lookup(input logic [LevelW-1:0] lvl);
    logic [GainW-1:0] g;
    case (lvl)
      4'd0:    g = 14'd0;
      4'd1:    g = 14'd230;
      4'd2:    g = 14'd410;
      4'd3:    g = 14'd728;
      4'd4:    g = 14'd1295;
      4'd5:    g = 14'd2303;
      4'd6:    g = 14'd4096;
      4'd7:    g = 14'd5157;
      4'd8:    g = 14'd6492;
      4'd9:    g = 14'd8173;
      4'd10:   g = 14'd10289;
      default: g = 14'd12953;
    endcase
    return g;
  endfunction

endpackage

@@ hw/rtl/vsbpd_scaler.sv @@
// Three-stage volume scaling: gain lookup, multiply, divide by 4096 and saturate.
module vsbpd_scaler (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  input  logic signed [vsbpd_pkg::SampleW-1:0] sample,
  input  logic [vsbpd_pkg::LevelW-1:0]         volume_level,
  output vsbpd_pkg::scale_out_t                result
);

  logic                                 valid_a;
  logic signed [vsbpd_pkg::SampleW-1:0] sample_a;
  logic [vsbpd_pkg::GainW-1:0]          gain_a;

  logic                                 valid_b;
  logic signed [vsbpd_pkg::ProdW-1:0]   product_b;

  logic                                 valid_c;
  logic [vsbpd_pkg::SampleW-1:0]        code_c;

  logic signed [vsbpd_pkg::ProdW-1:0]   biased;
  logic signed [vsbpd_pkg::ProdW-13:0]  quotient;
  logic [vsbpd_pkg::SampleW-1:0]        saturated;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= 1'b0;
      valid_b <= 1'b0;
      valid_c <= 1'b0;
    end else begin
      valid_a <= in_valid;
      valid_b <= valid_a;
      valid_c <= valid_b;
    end
  end

  always_ff @(posedge clk) begin
    sample_a  <= sample;
    gain_a    <= vsbpd_pkg::gain_lookup(volume_level);
    product_b <= $signed({{(vsbpd_pkg::ProdW-vsbpd_pkg::SampleW){sample_a[vsbpd_pkg::SampleW-1]}},
                          sample_a}) *
                 $signed({{(vsbpd_pkg::ProdW-vsbpd_pkg::GainW){1'b0}}, gain_a});
    code_c    <= saturated ^ vsbpd_pkg::SignFlip;
  end

  assign result = '{valid: valid_c, code: code_c};

  // Truncate toward zero: bias negative products before the arithmetic shift.
  always_comb begin
    biased   = product_b + (product_b[vsbpd_pkg::ProdW-1] ? 31'sd4095 : 31'sd0);
    quotient = biased[vsbpd_pkg::ProdW-1:12];
    if (quotient > 19'sd32767) begin
      saturated = vsbpd_pkg::SatHigh;
    end else if (quotient < -19'sd32767) begin
      saturated = vsbpd_pkg::SatLow;
    end else begin
      saturated = quotient[vsbpd_pkg::SampleW-1:0];
    end
  end

endmodule

@@ hw/rtl/volume_scaled_bipolar_pwm_dac.sv @@
// Top level of the volume-scaled bipolar PWM DAC: config registers and PWM mapping.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+-------------------------------------
//  sample   | start, busy (always low)   | sample[15:0] signed
//  config   | cfg_valid, cfg_ready       | cfg_index[1:0], cfg_data[15:0]
//  result   | result_valid (one cycle)   | pwm_positive[15:0], pwm_negative[15:0]
//
// A sample passes through five register stages in order: gain lookup, gain
// multiply, divide/saturate, period multiply and pin select, the last of which
// drives the result ports.
// One sample enters per clock, since no stage ever holds.
// rst is synchronous and active high: it clears every valid bit, sets the
// volume level to unity (level 6) and the PWM period to zero.
// The result receiver cannot stall, so the pipe never holds; busy stays low.
module volume_scaled_bipolar_pwm_dac (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [vsbpd_pkg::SampleW-1:0]  sample,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [vsbpd_pkg::CfgIdxW-1:0]         cfg_index,
  input  logic [vsbpd_pkg::CfgDataW-1:0]        cfg_data,
  output logic                                  result_valid,
  output logic [vsbpd_pkg::SampleW-1:0]         pwm_positive,
  output logic [vsbpd_pkg::SampleW-1:0]         pwm_negative
);

`include "volume_scaled_bipolar_pwm_dac_defines.svh"

  // Configuration registers
  logic [vsbpd_pkg::LevelW-1:0]  volume_level;
  logic [vsbpd_pkg::SampleW-1:0] pwm_period;

  // Scaling pipe output
  vsbpd_pkg::scale_out_t scaled;

  // Period multiply stage
  logic                            valid_d;
  logic                            positive_d;
  logic [vsbpd_pkg::SampleW-1:0]   prod_d;
  logic [2*vsbpd_pkg::SampleW-2:0] frac_product;

  logic accept;

  // The pipe never stalls, so a sample transfer is taken on every cycle.
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // Config writes: drop volume levels above twelve, ignore unknown indexes.
  always_ff @(posedge clk) begin
    if (rst) begin
      volume_level <= vsbpd_pkg::LevelReset;
      pwm_period   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        vsbpd_pkg::CfgVolume: begin
          if (cfg_data[vsbpd_pkg::LevelW-1:0] <= vsbpd_pkg::LevelMax) begin
            volume_level <= cfg_data[vsbpd_pkg::LevelW-1:0];
          end
        end
        vsbpd_pkg::CfgPeriod: begin
          pwm_period <= cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  // Stages one to three: sample times gain, divided by 4096, saturated, offset binary.
  vsbpd_scaler u_scaler (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (accept),
    .sample       (sample),
    .volume_level (volume_level),
    .result       (scaled)
  );

  // Stage four: scale the 15-bit magnitude by the period, keep the top 16 bits.
  assign frac_product = {{vsbpd_pkg::SampleW{1'b0}}, scaled.code[vsbpd_pkg::SampleW-2:0]} *
                        {{(vsbpd_pkg::SampleW-1){1'b0}}, pwm_period};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_d      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      valid_d      <= scaled.valid;
      result_valid <= valid_d;
    end
  end

  // Stage five: steer the compare value to one pin; the negative pin counts down
  // from the period.
  always_ff @(posedge clk) begin
    positive_d <= scaled.code[vsbpd_pkg::SampleW-1];
    prod_d     <= frac_product[2*vsbpd_pkg::SampleW-2:vsbpd_pkg::SampleW-1];
    if (positive_d) begin
      pwm_positive <= prod_d;
      pwm_negative <= '0;
    end else begin
      pwm_positive <= '0;
      pwm_negative <= pwm_period - prod_d;
    end
  end

  // Every accepted sample yields a result.
  `VSBPD_ASSERT_IMPLY(a_latency, clk, rst, accept, ##5 result_valid)
  // No result appears without an accepted sample ahead of it.
  `VSBPD_ASSERT_IMPLY(a_no_phantom, clk, rst, result_valid, $past(accept, 5))
  // At most one pin carries a non-zero compare value.
  `VSBPD_ASSERT_IMPLY(a_one_pin, clk, rst, result_valid,
                      pwm_positive == '0 || pwm_negative == '0)
  // Compare values never exceed the PWM period.
  `VSBPD_ASSERT_IMPLY(a_in_period, clk, rst, result_valid,
                      pwm_positive <= pwm_period && pwm_negative <= pwm_period)

endmodule

@@ verif/volume_scaled_bipolar_pwm_dac_tb.sv @@
// Self-checking testbench for the volume-scaled bipolar PWM DAC.
module volume_scaled_bipolar_pwm_dac_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import vsbpd_pkg::*;

  // Register indexes past the end of the register list: writes there do nothing.
  localparam logic [CfgIdxW-1:0] CfgSpareA = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgSpareB = 2'd3;

  // Cycles with no transfer of any kind before the run is declared hung.
  localparam int StallLimit = 2000;
  // Cycles to wait after the last expected result before the verdict.
  localparam int TailCycles = 8;

  // Expected compare pair for one sample, with the sample kept for messages.
  typedef struct packed {
    logic [SampleW-1:0] smp;
    logic [SampleW-1:0] pos;
    logic [SampleW-1:0] neg;
  } pwm_pair_t;

  logic                        clk;
  logic                        rst;
  logic                        start;
  logic                        busy;
  logic signed [SampleW-1:0]   sample;
  logic                        cfg_valid;
  logic                        cfg_ready;
  logic [CfgIdxW-1:0]          cfg_index;
  logic [CfgDataW-1:0]         cfg_data;
  logic                        result_valid;
  logic [SampleW-1:0]          pwm_positive;
  logic [SampleW-1:0]          pwm_negative;

  // Shadow of the two configuration registers, as the block should hold them.
  logic [LevelW-1:0]   level_shadow;
  logic [CfgDataW-1:0] period_shadow;

  pwm_pair_t pending_pwm[$];
  int        mismatch_count;
  int        stall_cycles;
  bit        idle_on;

  // Gain per volume level in Q12; unity is 4096.
  int gain_q12 [12] = '{0, 230, 410, 728, 1295, 2303, 4096, 5157, 6492, 8173, 10289, 12953};

  volume_scaled_bipolar_pwm_dac dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .sample       (sample),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .pwm_positive (pwm_positive),
    .pwm_negative (pwm_negative)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Scale the sample by the level's gain, saturate, flip to offset binary and
  // map the code onto whichever pin owns that half of the range.
  function automatic pwm_pair_t predict_pwm(logic signed [SampleW-1:0] s,
                                            logic [LevelW-1:0] lvl,
                                            logic [CfgDataW-1:0] per);
    pwm_pair_t          r;
    int                 g;
    int                 v;
    logic [SampleW-1:0] code;
    logic [31:0]        prod;
    g = (lvl >= LevelMax) ? gain_q12[11] : gain_q12[lvl];
    // SV integer division truncates toward zero, as required.
    v = (int'(s) * g) / 4096;
    if (v > 32767) v = 32767;
    if (v < -32767) v = -32768;
    code = v[SampleW-1:0] ^ SignFlip;
    prod = ({17'd0, code[SampleW-2:0]} * {16'd0, per}) >> 15;
    r.smp = s;
    if (code[SampleW-1]) begin
      r.pos = prod[SampleW-1:0];
      r.neg = '0;
    end else begin
      r.pos = '0;
      r.neg = per - prod[SampleW-1:0];
    end
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Drive one sample and hold it until the block takes it; record the expectation.
  task automatic send_sample(logic signed [SampleW-1:0] s);
    @(negedge clk);
    start  = 1'b1;
    sample = s;
    do @(posedge clk); while (busy);
    pending_pwm.push_back(predict_pwm(s, level_shadow, period_shadow));
  endtask

  // Hold start low with junk on the sample port; n sets the length of the gap.
  task automatic idle_gap(int n);
    repeat (n) begin
      @(negedge clk);
      start  = 1'b0;
      sample = 16'($urandom);
    end
  endtask

  // Stop sending and wait for every outstanding result to come back.
  task automatic wait_drained();
    @(negedge clk);
    start = 1'b0;
    while (pending_pwm.size() != 0) @(posedge clk);
  endtask

  // Write one register through the config channel once the pipe is empty.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    wait_drained();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CfgVolume: if (data[LevelW-1:0] <= LevelMax) level_shadow = data[LevelW-1:0];
      CfgPeriod: period_shadow = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
    cfg_index = 2'($urandom);
    cfg_data  = 16'($urandom);
  endtask

  // Mostly full-range noise, with a share of extremes and of quiet signals.
  function automatic logic signed [SampleW-1:0] pick_sample();
    logic signed [SampleW-1:0] s;
    case ($urandom_range(0, 7))
      0: s = 16'sh7FFF - 16'($urandom_range(0, 255));
      1: s = 16'sh8000 + 16'($urandom_range(0, 255));
      2: s = 16'($urandom_range(0, 600)) - 16'sd300;
      default: s = 16'($urandom);
    endcase
    return s;
  endfunction

  // Out of reset the period is zero, so both pins must read zero.
  task automatic test_reset_defaults();
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
  endtask

  // Full-scale period at unity gain, across the sign boundary and both rails.
  task automatic test_sample_extremes();
    write_reg(CfgPeriod, 16'hFFFF);
    send_sample(16'sh8000);
    send_sample(16'sh8001);
    send_sample(-16'sd1);
    send_sample(16'sd0);
    send_sample(16'sd1);
    send_sample(16'sh7FFF);
  endtask

  // Every level once, alternating rails so the top levels hit saturation
  // and level twelve must repeat the gain of eleven.
  task automatic test_volume_levels();
    write_reg(CfgPeriod, 16'd40000);
    for (int lvl = 0; lvl <= LevelMax; lvl++) begin
      write_reg(CfgVolume, 16'(lvl));
      send_sample((lvl % 2) ? 16'sh8000 : 16'sh7FFF);
    end
  endtask

  // Levels above twelve and spare indexes must leave the registers alone.
  task automatic test_ignored_writes();
    write_reg(CfgVolume, 16'd9);
    for (int lvl = LevelMax + 1; lvl < (1 << LevelW); lvl++)
      write_reg(CfgVolume, 16'hFFF0 | 16'(lvl));
    write_reg(CfgSpareA, 16'h0000);
    write_reg(CfgSpareB, 16'h0003);
    send_sample(16'sh4000);
    send_sample(-16'sh4000);
  endtask

  // Phases of random samples, each under its own configuration. The first
  // phases pin the extremes; the last two run without any idle cycles.
  task automatic test_random_phases();
    localparam int Phases = 12;
    localparam int PerPhase = 152;
    logic [CfgDataW-1:0] per;
    logic [LevelW-1:0]   lvl;
    for (int ph = 0; ph < Phases; ph++) begin
      case (ph)
        0: begin lvl = LevelMax;  per = 16'hFFFF; end
        1: begin lvl = 4'd0;      per = 16'hFFFF; end
        2: begin lvl = LevelMax;  per = 16'h0000; end
        3: begin lvl = 4'd11;     per = 16'h0001; end
        4: begin lvl = LevelReset; per = 16'h8000; end
        default: begin
          lvl = 4'($urandom_range(0, 15));
          per = 16'($urandom);
        end
      endcase
      write_reg(CfgVolume, {12'($urandom), lvl});
      write_reg(CfgPeriod, per);
      // Bursts of idle in all phases but every third one; none in the last two.
      idle_on = (ph < Phases - 2) && (ph % 3 != 2);
      for (int i = 0; i < PerPhase; i++) begin
        send_sample(pick_sample());
        if (idle_on && $urandom_range(0, 3) == 0) idle_gap($urandom_range(1, 10));
      end
    end
  endtask

  // Compare each result with the oldest expectation; the result is on the
  // ports for one cycle only, so it is taken at the edge that ends it.
  always @(posedge clk) begin
    pwm_pair_t exp_pwm;
    if (!rst && result_valid) begin
      if (pending_pwm.size() == 0) begin
        report_mismatch($sformatf("result pos=%0d neg=%0d with nothing expected",
                                  pwm_positive, pwm_negative));
      end else begin
        exp_pwm = pending_pwm.pop_front();
        if (pwm_positive !== exp_pwm.pos)
          report_mismatch($sformatf("sample %0d: pwm_positive %0d, expected %0d",
                                    $signed(exp_pwm.smp), pwm_positive, exp_pwm.pos));
        if (pwm_negative !== exp_pwm.neg)
          report_mismatch($sformatf("sample %0d: pwm_negative %0d, expected %0d",
                                    $signed(exp_pwm.smp), pwm_negative, exp_pwm.neg));
      end
    end
  end

  // Watchdog: count cycles in which no transfer of any kind happens.
  always @(posedge clk) begin
    if (rst || (start && !busy) || (cfg_valid && cfg_ready) || result_valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("watchdog: no transfer for %0d cycles", StallLimit);
      $display("FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst            = 1'b1;
    start          = 1'b0;
    sample         = '0;
    cfg_valid      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    mismatch_count = 0;
    stall_cycles   = 0;
    idle_on        = 1'b0;
    level_shadow   = LevelReset;
    period_shadow  = '0;

    // Hold reset from the start, then release it away from the active edge.
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_defaults();
    test_sample_extremes();
    test_volume_levels();
    test_ignored_writes();
    test_random_phases();

    // Drain the pipe, then wait out the tail to show any stray result.
    wait_drained();
    repeat (TailCycles) @(posedge clk);
    if (mismatch_count == 0 && pending_pwm.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
